// File: hw/rtl/nia_pkg.sv
// ----------------------------------------------------------------------------
// nia_pkg
// Shared types and constants for the nearest idle unit assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package nia_pkg;

    localparam int ID_W    = 16;
    localparam int POS_W   = 16;
    localparam int DIST_W  = 33;
    localparam int OSLOT_W = 7;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 33'd1000000;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    idle;
    } t_entry;

    typedef struct packed {
        logic start;   // load limit as best, clear found and pick
        logic valid;   // entry at ring head is presented
        logic elig;    // entry is filled and idle
    } t_dist_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/nia_cell.sv
// ----------------------------------------------------------------------------
// nia_cell
// One slot of the unit ring; takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module nia_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire nia_pkg::t_entry i_entry,
    output nia_pkg::t_entry      o_entry
);
    import nia_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: hw/rtl/nia_dist.sv
// ----------------------------------------------------------------------------
// nia_dist
// Pipelined squared distance and running minimum over the ring head stream.
// ----------------------------------------------------------------------------
`default_nettype none

module nia_dist #(
    parameter int SLOT_W = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire nia_pkg::t_dist_ctl          i_ctl,
    input  wire logic [SLOT_W-1:0]           i_slot,
    input  wire logic signed [15:0]          i_tx,
    input  wire logic signed [15:0]          i_ty,
    input  wire logic signed [15:0]          i_ux,
    input  wire logic signed [15:0]          i_uy,
    input  wire logic [32:0]                 i_limit,
    output logic                             o_busy,
    output logic                             o_found,
    output logic [SLOT_W-1:0]                o_pick
);
    import nia_pkg::*;

    logic                r_s1_v;
    logic                r_s1_e;
    logic [SLOT_W-1:0]   r_s1_slot;
    logic signed [16:0]  r_dx;
    logic signed [16:0]  r_dy;
    logic                r_s2_v;
    logic                r_s2_e;
    logic [SLOT_W-1:0]   r_s2_slot;
    logic [31:0]         r_sqx;
    logic [31:0]         r_sqy;
    logic [DIST_W-1:0]   r_best;
    logic                r_found;
    logic [SLOT_W-1:0]   r_pick;

    logic signed [16:0]  n_dx;
    logic signed [16:0]  n_dy;
    logic signed [33:0]  w_px;
    logic signed [33:0]  w_py;
    logic [DIST_W-1:0]   w_d;

    assign n_dx = $signed({i_ux[15], i_ux}) - $signed({i_tx[15], i_tx});
    assign n_dy = $signed({i_uy[15], i_uy}) - $signed({i_ty[15], i_ty});
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_d  = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_s1_v <= i_ctl.valid;
            r_s2_v <= r_s1_v;
            if (i_ctl.start) begin
                r_found <= 1'b0;
            end else if (r_s2_v && r_s2_e && (w_d < r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_e    <= i_ctl.elig;
        r_s1_slot <= i_slot;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_s2_e    <= r_s1_e;
        r_s2_slot <= r_s1_slot;
        r_sqx     <= w_px[31:0];
        r_sqy     <= w_py[31:0];
        if (i_ctl.start) begin
            r_best <= i_limit;
            r_pick <= '0;
        end else if (r_s2_v && r_s2_e && (w_d < r_best)) begin
            r_best <= w_d;
            r_pick <= r_s2_slot;
        end
    end

    assign o_busy  = r_s1_v | r_s2_v;
    assign o_found = r_found;
    assign o_pick  = r_pick;

endmodule

`default_nettype wire

// File: hw/rtl/nearest_idle_unit_assigner.sv
// ----------------------------------------------------------------------------
// nearest_idle_unit_assigner
// Unit table kept in a rotating ring of cells; status updates and nearest
// idle unit assignment.
//
// Input stream s_axis: tuser = mode (0 update, 1 request); tdata carries the
// unit id, position and idle mark. Output stream m_axis: one result per
// input transaction. i_cfg_we / i_cfg_wdata write the squared distance limit.
//
// The table rotates through TABLE_DEPTH cells, one slot passing the head per
// cycle; the head feeds the id compare and a 3-stage distance pipeline.
// An update makes one rotation from accept to result. A request makes one
// rotation and waits for the distance pipeline to drain; when a unit is
// chosen, a second rotation clears that unit's idle mark. One transaction is
// in flight at a time; the next is accepted once the result is registered,
// even while m_axis is stalled. A stalled result holds in the output register
// and blocks the next result only.
// Reset empties the table and loads the limit with 1000000; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_idle_unit_assigner #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // unit_id, pos_x, pos_y, is_idle
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // assigned, slot, chosen_id,
                                            // tgt_x, tgt_y, dropped
    input  wire logic        i_cfg_we,
    input  wire logic [32:0] i_cfg_wdata
);
    import nia_pkg::*;

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_CLEAR = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state              r_state;
    logic [DIST_W-1:0]   r_max_dist;
    logic [CNT_W-1:0]    r_count;
    logic [SLOT_W-1:0]   r_idx;
    logic                r_mode;
    logic [ID_W-1:0]     r_id;
    logic signed [15:0]  r_x;
    logic signed [15:0]  r_y;
    logic                r_idle;
    logic                r_hit;
    logic                r_app;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [ID_W-1:0]     r_res_id;
    logic                r_out_valid;
    logic [63:0]         r_out_data;

    t_entry              w_cell [TABLE_DEPTH];
    t_entry              w_head;
    t_entry              w_wb;
    t_dist_ctl           w_ctl;
    logic                w_shift;
    logic                w_accept;
    logic                w_in_range;
    logic                w_match;
    logic                w_append;
    logic                w_clear_hit;
    logic                w_dist_busy;
    logic                w_found;
    logic [SLOT_W-1:0]   w_pick;
    logic                w_out_free;
    logic [63:0]         n_out_data;

    assign w_head      = w_cell[0];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_shift     = (r_state == ST_SCAN) || (r_state == ST_CLEAR);
    assign w_in_range  = CNT_W'(r_idx) < r_count;
    assign w_match     = (r_state == ST_SCAN) && !r_mode && w_in_range
                         && (w_head.id == r_id);
    assign w_append    = (r_state == ST_SCAN) && !r_mode && !r_hit
                         && (CNT_W'(r_idx) == r_count);
    assign w_clear_hit = (r_state == ST_CLEAR) && (r_idx == w_pick);
    assign w_out_free  = !r_out_valid || m_axis_tready;

    always_comb begin
        w_wb = w_head;
        if (w_match) begin
            w_wb.x    = r_x;
            w_wb.y    = r_y;
            w_wb.idle = r_idle;
        end else if (w_append) begin
            w_wb.id   = r_id;
            w_wb.x    = r_x;
            w_wb.y    = r_y;
            w_wb.idle = r_idle;
        end
        if (w_clear_hit) begin
            w_wb.idle = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_ring
            if (gi == TABLE_DEPTH - 1) begin : g_tail
                nia_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_entry (w_wb),
                    .o_entry (w_cell[gi])
                );
            end else begin : g_body
                nia_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_entry (w_cell[gi+1]),
                    .o_entry (w_cell[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        w_ctl.start = w_accept;
        w_ctl.valid = (r_state == ST_SCAN) && r_mode;
        w_ctl.elig  = w_in_range && w_head.idle;
    end

    nia_dist #(
        .SLOT_W (SLOT_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_slot  (r_idx),
        .i_tx    (r_x),
        .i_ty    (r_y),
        .i_ux    (w_head.x),
        .i_uy    (w_head.y),
        .i_limit (r_max_dist),
        .o_busy  (w_dist_busy),
        .o_found (w_found),
        .o_pick  (w_pick)
    );

    always_comb begin
        n_out_data = '0;
        if (r_mode) begin
            if (w_found) begin
                n_out_data[0]     = 1'b1;
                n_out_data[7:1]   = OSLOT_W'(w_pick);
                n_out_data[23:8]  = r_res_id;
                n_out_data[39:24] = r_x;
                n_out_data[55:40] = r_y;
            end
        end else if (r_hit || r_app) begin
            n_out_data[7:1]  = OSLOT_W'(r_res_slot);
            n_out_data[23:8] = r_id;
        end else begin
            n_out_data[56] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max_dist  <= MAX_DIST_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_app       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_dist <= i_cfg_wdata;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_app   <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_match) begin
                        r_hit <= 1'b1;
                    end
                    if (w_append) begin
                        r_app <= 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= r_mode ? ST_DRAIN : ST_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!w_dist_busy) begin
                        r_state <= w_found ? ST_CLEAR : ST_DONE;
                    end
                end
                ST_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_app) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= s_axis_tuser;
            r_id   <= s_axis_tdata[15:0];
            r_x    <= s_axis_tdata[31:16];
            r_y    <= s_axis_tdata[47:32];
            r_idle <= s_axis_tdata[48];
        end
        if (w_match || w_append) begin
            r_res_slot <= r_idx;
        end
        if (w_clear_hit) begin
            r_res_id <= w_head.id;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !(r_hit && r_app))
        else $error("update both matched and appended");

    a_pick_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (CNT_W'(w_pick) < r_count))
        else $error("chosen slot outside filled table");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && !r_mode && !r_hit && !r_app)
            |-> (r_count == CNT_W'(TABLE_DEPTH)))
        else $error("drop reported with room in table");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("second transaction taken while busy");

endmodule

`default_nettype wire
